// ===== rtl/wgcs_pkg.sv =====
`default_nettype none

package wgcs_pkg;

	// Number of generators behind the slave; higher ids are rejected.
	localparam int NUM_GENERATORS = 2;

	localparam logic [3:0]  ALERT_NIBBLE = 4'hA;
	localparam logic [3:0]  CMD_PIN      = 4'hA;
	localparam logic [3:0]  CMD_VOLT     = 4'hB;
	localparam logic [3:0]  CMD_FREQ     = 4'hC;
	localparam logic [3:0]  CMD_SHAPE    = 4'hD;
	localparam logic [15:0] COMMIT_WORD  = 16'hF000;

	localparam logic [7:0]  PIN_LIMIT    = 8'd32;
	localparam logic [7:0]  VOLT_MAX     = 8'd100;
	localparam logic [15:0] FREQ_MIN     = 16'd50;
	localparam logic [15:0] FREQ_MAX     = 16'd50000;
	localparam logic [3:0]  SHAPE_LIMIT  = 4'd5;

	localparam logic [15:0] FREQ_RESET   = 16'd1000;
	localparam logic [6:0]  AMP_RESET    = 7'd100;

	typedef enum logic [2:0] {
		PH_ALERT = 3'd0,
		PH_PIN   = 3'd1,
		PH_VOLT  = 3'd2,
		PH_FREQ  = 3'd3,
		PH_SHAPE = 3'd4,
		PH_WAIT  = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		KIND_NONE  = 3'd0,
		KIND_PIN   = 3'd1,
		KIND_VOLT  = 3'd2,
		KIND_FREQ  = 3'd3,
		KIND_SHAPE = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		EV_WAIT     = 3'd0,
		EV_STOP     = 3'd1,
		EV_COMMIT   = 3'd2,
		EV_REJECT   = 3'd3,
		EV_REPEAT   = 3'd4,
		EV_NOTALERT = 3'd5
	} event_t;

	localparam logic [2:0] SHAPE_SQUARE = 3'd0;

	typedef struct packed {
		event_t      ev;
		logic        gen_id;
		logic        running;
		logic [15:0] freq;
		logic [6:0]  amp;
		logic [2:0]  shape;
		logic [4:0]  chan;
		logic        err;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/wgcs_core.sv =====
`default_nettype none

module wgcs_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            take,
	input  wire logic [15:0]     word,
	output wgcs_pkg::result_t    res
);

	wgcs_pkg::phase_t phase_q, phase_d;
	wgcs_pkg::kind_t  kind_q, kind_d;
	logic        sel_q, sel_d;
	logic [15:0] pend_q, pend_d;
	logic [15:0] prev_q, prev_d;
	logic        err_q, err_d;

	logic [15:0] freq_q [wgcs_pkg::NUM_GENERATORS];
	logic [6:0]  amp_q  [wgcs_pkg::NUM_GENERATORS];
	logic [2:0]  shape_q[wgcs_pkg::NUM_GENERATORS];
	logic [4:0]  chan_q [wgcs_pkg::NUM_GENERATORS];
	logic        on_q   [wgcs_pkg::NUM_GENERATORS];
	logic [15:0] freq_d [wgcs_pkg::NUM_GENERATORS];
	logic [6:0]  amp_d  [wgcs_pkg::NUM_GENERATORS];
	logic [2:0]  shape_d[wgcs_pkg::NUM_GENERATORS];
	logic [4:0]  chan_d [wgcs_pkg::NUM_GENERATORS];
	logic        on_d   [wgcs_pkg::NUM_GENERATORS];

	wgcs_pkg::event_t ev;

	always_comb begin
		logic       reject;
		logic [3:0] id;
		logic [3:0] onf;
		logic [3:0] cmd;
		reject  = 1'b0;
		id      = word[7:4];
		onf     = word[11:8];
		cmd     = word[3:0];
		phase_d = phase_q;
		kind_d  = kind_q;
		sel_d   = sel_q;
		pend_d  = pend_q;
		prev_d  = prev_q;
		err_d   = err_q;
		freq_d  = freq_q;
		amp_d   = amp_q;
		shape_d = shape_q;
		chan_d  = chan_q;
		on_d    = on_q;
		ev      = wgcs_pkg::EV_WAIT;

		if (word == prev_q) begin
			ev = wgcs_pkg::EV_REPEAT;
		end else begin
			prev_d = word;
			case (phase_q)
				wgcs_pkg::PH_ALERT: begin
					if (word[15:12] != wgcs_pkg::ALERT_NIBBLE) begin
						ev = wgcs_pkg::EV_NOTALERT;
					end else if (id >= 4'(wgcs_pkg::NUM_GENERATORS)) begin
						reject = 1'b1;
					end else begin
						sel_d  = id[0];
						kind_d = wgcs_pkg::KIND_NONE;
						pend_d = '0;
						if (onf == 4'd0) begin
							on_d[id[0]] = 1'b0;
							phase_d     = wgcs_pkg::PH_WAIT;
							ev          = wgcs_pkg::EV_STOP;
						end else begin
							case (cmd)
								wgcs_pkg::CMD_PIN:   phase_d = wgcs_pkg::PH_PIN;
								wgcs_pkg::CMD_VOLT:  phase_d = wgcs_pkg::PH_VOLT;
								wgcs_pkg::CMD_FREQ:  phase_d = wgcs_pkg::PH_FREQ;
								wgcs_pkg::CMD_SHAPE: phase_d = wgcs_pkg::PH_SHAPE;
								default:             reject  = 1'b1;
							endcase
						end
					end
				end
				wgcs_pkg::PH_PIN: begin
					if (word[7:0] < wgcs_pkg::PIN_LIMIT) begin
						kind_d  = wgcs_pkg::KIND_PIN;
						pend_d  = {8'd0, word[7:0]};
						phase_d = wgcs_pkg::PH_WAIT;
					end else begin
						reject = 1'b1;
					end
				end
				wgcs_pkg::PH_VOLT: begin
					if (word[7:0] <= wgcs_pkg::VOLT_MAX) begin
						kind_d  = wgcs_pkg::KIND_VOLT;
						pend_d  = {8'd0, word[7:0]};
						phase_d = wgcs_pkg::PH_WAIT;
					end else begin
						reject = 1'b1;
					end
				end
				wgcs_pkg::PH_FREQ: begin
					if (word >= wgcs_pkg::FREQ_MIN && word <= wgcs_pkg::FREQ_MAX) begin
						kind_d  = wgcs_pkg::KIND_FREQ;
						pend_d  = word;
						phase_d = wgcs_pkg::PH_WAIT;
					end else begin
						reject = 1'b1;
					end
				end
				wgcs_pkg::PH_SHAPE: begin
					if (word[3:0] < wgcs_pkg::SHAPE_LIMIT) begin
						kind_d  = wgcs_pkg::KIND_SHAPE;
						pend_d  = {12'd0, word[3:0]};
						phase_d = wgcs_pkg::PH_WAIT;
					end else begin
						reject = 1'b1;
					end
				end
				wgcs_pkg::PH_WAIT: begin
					if (word == wgcs_pkg::COMMIT_WORD) begin
						case (kind_q)
							wgcs_pkg::KIND_PIN: chan_d[sel_q] = pend_q[4:0];
							wgcs_pkg::KIND_VOLT: begin
								amp_d[sel_q] = pend_q[6:0];
								on_d[sel_q]  = 1'b1;
							end
							wgcs_pkg::KIND_FREQ: begin
								freq_d[sel_q] = pend_q;
								on_d[sel_q]   = 1'b1;
							end
							wgcs_pkg::KIND_SHAPE: begin
								shape_d[sel_q] = pend_q[2:0];
								on_d[sel_q]    = 1'b1;
							end
							default: ;
						endcase
						kind_d  = wgcs_pkg::KIND_NONE;
						pend_d  = '0;
						phase_d = wgcs_pkg::PH_ALERT;
						ev      = wgcs_pkg::EV_COMMIT;
					end else begin
						reject = 1'b1;
					end
				end
				default: reject = 1'b1;
			endcase
			if (reject) begin
				phase_d = wgcs_pkg::PH_ALERT;
				kind_d  = wgcs_pkg::KIND_NONE;
				pend_d  = '0;
				sel_d   = 1'b0;
				err_d   = ~err_q;
				ev      = wgcs_pkg::EV_REJECT;
			end
		end

		res.ev      = ev;
		res.gen_id  = sel_d;
		res.running = on_d[sel_d];
		res.freq    = freq_d[sel_d];
		res.amp     = amp_d[sel_d];
		res.shape   = shape_d[sel_d];
		res.chan    = chan_d[sel_d];
		res.err     = err_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= wgcs_pkg::PH_ALERT;
			kind_q  <= wgcs_pkg::KIND_NONE;
			sel_q   <= 1'b0;
			pend_q  <= '0;
			prev_q  <= '0;
			err_q   <= 1'b0;
			for (int i = 0; i < wgcs_pkg::NUM_GENERATORS; i++) begin
				freq_q[i]  <= wgcs_pkg::FREQ_RESET;
				amp_q[i]   <= wgcs_pkg::AMP_RESET;
				shape_q[i] <= wgcs_pkg::SHAPE_SQUARE;
				chan_q[i]  <= 5'(i);
				on_q[i]    <= 1'b0;
			end
		end else if (take) begin
			phase_q <= phase_d;
			kind_q  <= kind_d;
			sel_q   <= sel_d;
			pend_q  <= pend_d;
			prev_q  <= prev_d;
			err_q   <= err_d;
			freq_q  <= freq_d;
			amp_q   <= amp_d;
			shape_q <= shape_d;
			chan_q  <= chan_d;
			on_q    <= on_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/waveform_generator_command_slave.sv =====
`default_nettype none

// Command slave for a pair of waveform generators. Each accepted input
// transaction carries one 16-bit word from the serial bus master and yields
// exactly one result transaction: an event code plus the addressed
// generator's stored settings and the error toggle as they stand after the
// word. A transaction on the bus is alert word (0xA o i c), value word, then
// commit word 0xF000; an alert with o = 0 stops the generator and skips the
// value word. A word equal to the one before is ignored, a bad word aborts
// and flips error_toggle. Rate: one word per clock. The state update is a
// single combinational pass from the word into the state registers, and the
// result lands in an output register backed by one skid register, so a word
// is taken every cycle until the skid fills under a stalled sink.

module waveform_generator_command_slave (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [15:0] word,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       event_res,
	output logic             gen_id,
	output logic             gen_running,
	output logic [15:0]      frequency_hz,
	output logic [6:0]       amplitude_pct,
	output logic [2:0]       wave_shape,
	output logic [4:0]       mux_channel,
	output logic             error_toggle
);

	wgcs_pkg::result_t res;
	wgcs_pkg::result_t out_q;
	wgcs_pkg::result_t skid_q;
	logic              out_valid_q;
	logic              skid_valid_q;
	logic              in_accept;
	logic              out_free;

	// Stall the source only while the skid holds a result.
	assign in_stall  = skid_valid_q;
	assign in_accept = in_valid && !skid_valid_q;
	// Output register can take a new result when empty or being drained.
	assign out_free  = !out_valid_q || !out_stall;

	wgcs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (in_accept),
		.word   (word),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				// Refill from the skid first, to keep result order.
				out_valid_q  <= skid_valid_q || in_accept;
				skid_valid_q <= 1'b0;
			end else if (in_accept) begin
				// Park the new result behind the stalled one.
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (in_accept) begin
				out_q <= res;
			end
		end else if (in_accept) begin
			skid_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign event_res     = out_q.ev;
	assign gen_id        = out_q.gen_id;
	assign gen_running   = out_q.running;
	assign frequency_hz  = out_q.freq;
	assign amplitude_pct = out_q.amp;
	assign wave_shape    = out_q.shape;
	assign mux_channel   = out_q.chan;
	assign error_toggle  = out_q.err;

	// The skid only ever holds a result queued behind the output register.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a result while output register is empty");

	// A word taken under a stalled, occupied output must land in the skid.
	a_park_in_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall && in_accept) |=> skid_valid_q)
		else $error("result lost while output stalled");

	// Draining the last result with nothing new leaves the output empty.
	a_drain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_stall && !skid_valid_q && !in_accept) |=> !out_valid_q)
		else $error("result repeated after drain");

endmodule

`default_nettype wire

// ===== verif/waveform_generator_command_slave_tb.sv =====
`default_nettype none

module waveform_generator_command_slave_tb;

	import wgcs_pkg::*;

	// Cycles with no transaction on either side before the run is declared hung.
	localparam int QUIET_LIMIT = 1000;
	// Length of the forced receiver hold-off used to back the block up.
	localparam int HOLD_OFF_CYCLES = 60;

	// Tracks the two generators' stored settings word by word and holds the
	// result each accepted word should produce, oldest first.
	class gen_settings_scoreboard;
		phase_t      phase;
		logic        sel;
		kind_t       kind;
		logic [15:0] pend_val;
		logic [15:0] prev_word;
		logic [15:0] freq [2];
		logic [6:0]  amp [2];
		logic [2:0]  shape [2];
		logic [4:0]  chan [2];
		logic        on [2];
		logic        err;
		result_t     settings_due [$];
		int          errors;

		function new();
			phase     = PH_ALERT;
			sel       = 1'b0;
			kind      = KIND_NONE;
			pend_val  = '0;
			prev_word = '0;
			err       = 1'b0;
			errors    = 0;
			for (int i = 0; i < 2; i++) begin
				freq[i]  = FREQ_RESET;
				amp[i]   = AMP_RESET;
				shape[i] = SHAPE_SQUARE;
				chan[i]  = 5'(i);
				on[i]    = 1'b0;
			end
		endfunction

		// Drop the bus transaction in progress and flip the error flag.
		function event_t abort_transaction();
			phase    = PH_ALERT;
			kind     = KIND_NONE;
			pend_val = '0;
			sel      = 1'b0;
			err      = ~err;
			return EV_REJECT;
		endfunction

		function event_t stage_value(kind_t k, logic [15:0] v, bit ok);
			if (!ok)
				return abort_transaction();
			kind     = k;
			pend_val = v;
			phase    = PH_WAIT;
			return EV_WAIT;
		endfunction

		function void take_word(logic [15:0] w);
			event_t  ev;
			logic [3:0] id;
			logic [3:0] onf;
			logic [3:0] cmd;
			result_t r;
			if (w == prev_word) begin
				ev = EV_REPEAT;
			end else begin
				prev_word = w;
				case (phase)
					PH_ALERT: begin
						id  = w[7:4];
						onf = w[11:8];
						cmd = w[3:0];
						if (w[15:12] != ALERT_NIBBLE) begin
							ev = EV_NOTALERT;
						end else if (id >= NUM_GENERATORS) begin
							ev = abort_transaction();
						end else begin
							sel      = id[0];
							kind     = KIND_NONE;
							pend_val = '0;
							ev       = EV_WAIT;
							if (onf == 4'h0) begin
								// Stop at once, then only the commit word is taken.
								on[sel] = 1'b0;
								phase   = PH_WAIT;
								ev      = EV_STOP;
							end else begin
								case (cmd)
									CMD_PIN:   phase = PH_PIN;
									CMD_VOLT:  phase = PH_VOLT;
									CMD_FREQ:  phase = PH_FREQ;
									CMD_SHAPE: phase = PH_SHAPE;
									default:   ev = abort_transaction();
								endcase
							end
						end
					end
					PH_PIN:   ev = stage_value(KIND_PIN, {8'h00, w[7:0]}, w[7:0] < PIN_LIMIT);
					PH_VOLT:  ev = stage_value(KIND_VOLT, {8'h00, w[7:0]}, w[7:0] <= VOLT_MAX);
					PH_FREQ:  ev = stage_value(KIND_FREQ, w, w >= FREQ_MIN && w <= FREQ_MAX);
					PH_SHAPE: ev = stage_value(KIND_SHAPE, {12'h000, w[3:0]},
						w[3:0] < SHAPE_LIMIT);
					PH_WAIT: begin
						if (w == COMMIT_WORD) begin
							// A pin commit only moves the mux; the others restart output.
							case (kind)
								KIND_PIN:   chan[sel] = pend_val[4:0];
								KIND_VOLT: begin
									amp[sel] = pend_val[6:0];
									on[sel]  = 1'b1;
								end
								KIND_FREQ: begin
									freq[sel] = pend_val;
									on[sel]   = 1'b1;
								end
								KIND_SHAPE: begin
									shape[sel] = pend_val[2:0];
									on[sel]    = 1'b1;
								end
								default: ;
							endcase
							kind     = KIND_NONE;
							pend_val = '0;
							phase    = PH_ALERT;
							ev       = EV_COMMIT;
						end else begin
							ev = abort_transaction();
						end
					end
					default: ev = abort_transaction();
				endcase
			end
			r.ev      = ev;
			r.gen_id  = sel;
			r.running = on[sel];
			r.freq    = freq[sel];
			r.amp     = amp[sel];
			r.shape   = shape[sel];
			r.chan    = chan[sel];
			r.err     = err;
			settings_due.push_back(r);
		endfunction

		function void compare_field(string what, logic [15:0] exp, logic [15:0] act);
			if (act !== exp) begin
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp, act);
				errors++;
			end
		endfunction

		function void check_report(result_t act);
			result_t exp;
			if (settings_due.size() == 0) begin
				$display("%0t: unexpected result, event %0d", $time, act.ev);
				errors++;
				return;
			end
			exp = settings_due.pop_front();
			compare_field("event_res", exp.ev, act.ev);
			compare_field("gen_id", exp.gen_id, act.gen_id);
			compare_field("gen_running", exp.running, act.running);
			compare_field("frequency_hz", exp.freq, act.freq);
			compare_field("amplitude_pct", exp.amp, act.amp);
			compare_field("wave_shape", exp.shape, act.shape);
			compare_field("mux_channel", exp.chan, act.chan);
			compare_field("error_toggle", exp.err, act.err);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [15:0] word;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  event_res;
	logic        gen_id;
	logic        gen_running;
	logic [15:0] frequency_hz;
	logic [6:0]  amplitude_pct;
	logic [2:0]  wave_shape;
	logic [4:0]  mux_channel;
	logic        error_toggle;

	gen_settings_scoreboard sb = new();

	int          idle_pct;     // sender: chance in 100 of an idle cycle before a word
	int          stall_pct;    // receiver: chance in 100 of a stall cycle
	int          hold_left;    // cycles of forced receiver hold-off still to run
	int          quiet_cycles;
	int          txn_words;    // words accepted by the block so far
	logic [15:0] last_word;

	waveform_generator_command_slave i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.word         (word),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.event_res    (event_res),
		.gen_id       (gen_id),
		.gen_running  (gen_running),
		.frequency_hz (frequency_hz),
		.amplitude_pct(amplitude_pct),
		.wave_shape   (wave_shape),
		.mux_channel  (mux_channel),
		.error_toggle (error_toggle)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Receiver side: stall at random, or hold off for a counted stretch when asked.
	// Drive at the falling edge so the block sees a settled value at the rising edge.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Monitor: check every result transaction against the oldest expectation.
	always @(posedge clk) begin
		result_t r;
		if (arst_n && out_valid && !out_stall) begin
			r.ev      = event_t'(event_res);
			r.gen_id  = gen_id;
			r.running = gen_running;
			r.freq    = frequency_hz;
			r.amp     = amplitude_pct;
			r.shape   = wave_shape;
			r.chan    = mux_channel;
			r.err     = error_toggle;
			sb.check_report(r);
		end
	end

	// Watchdog: count cycles in which neither side moves a transaction.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// Offer one word and hold it until accepted; returns at the accepting edge.
	// Random idle cycles go in front, and the payload is scrambled while idle.
	task automatic send_word(input logic [15:0] w);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
			word     <= 16'($urandom);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		word     <= w;
		do
			@(posedge clk);
		while (in_stall);
		sb.take_word(w);
		last_word = w;
		txn_words++;
	endtask

	// Lower valid and wait until every expected result has come back.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.settings_due.size() != 0)
			@(posedge clk);
	endtask

	// Value word for a command; a bad one lands outside the legal range.
	function automatic logic [15:0] pick_value(logic [3:0] cmd, bit good);
		logic [15:0] r;
		int          pick;
		r    = 16'($urandom);
		pick = $urandom_range(99);
		case (cmd)
			CMD_PIN:
				return good ? {r[15:8], 3'b000, r[4:0]}
					: {r[15:8], 8'($urandom_range(255, 32))};
			CMD_VOLT:
				return good ? {r[15:8], 8'($urandom_range(100))}
					: {r[15:8], 8'($urandom_range(255, 101))};
			CMD_FREQ: begin
				if (!good)
					return pick < 50 ? 16'($urandom_range(49))
						: 16'($urandom_range(65535, 50001));
				if (pick < 15)
					return FREQ_MIN;
				if (pick < 30)
					return FREQ_MAX;
				return 16'($urandom_range(50000, 50));
			end
			CMD_SHAPE:
				return good ? {r[15:4], 4'($urandom_range(4))}
					: {r[15:4], 4'($urandom_range(15, 5))};
			default:
				return r;
		endcase
	endfunction

	// Mostly well-formed alert/value/commit sequences with random content,
	// the rest noise: stray words, random alerts and repeats.
	task automatic random_transaction();
		logic [3:0] id;
		logic [3:0] onf;
		logic [3:0] cmd;
		int         pick;
		pick = $urandom_range(99);
		if (pick < 72) begin
			id  = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 2))
				: 4'($urandom_range(1));
			onf = ($urandom_range(9) == 0) ? 4'h0 : 4'($urandom_range(15, 1));
			cmd = ($urandom_range(29) == 0) ? 4'($urandom)
				: CMD_PIN + 4'($urandom_range(3));
			send_word({ALERT_NIBBLE, onf, id, cmd});
			if (onf != 4'h0)
				send_word(pick_value(cmd, $urandom_range(9) != 0));
			send_word(($urandom_range(24) == 0) ? 16'($urandom) : COMMIT_WORD);
		end else if (pick < 84) begin
			send_word(16'($urandom));
		end else if (pick < 94) begin
			send_word({ALERT_NIBBLE, 12'($urandom)});
		end else begin
			send_word(last_word);
		end
	endtask

	// One random phase at a given idle/stall mix; optionally force a long
	// receiver hold-off halfway through while the sender keeps pushing.
	task automatic run_phase(input int sender_idle, input int recv_stall, input int n,
		input bit squeeze);
		int target;
		bit squeezed;
		idle_pct  = sender_idle;
		stall_pct = recv_stall;
		target    = txn_words + n;
		squeezed  = 1'b0;
		while (txn_words < target) begin
			random_transaction();
			if (squeeze && !squeezed && txn_words >= target - n / 2) begin
				hold_left = HOLD_OFF_CYCLES;
				squeezed  = 1'b1;
			end
		end
		drain();
	endtask

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		word         = '0;
		out_stall    = 1'b0;
		idle_pct     = 0;
		stall_pct    = 0;
		hold_left    = 0;
		quiet_cycles = 0;
		txn_words    = 0;
		last_word    = '0;

		// Hold reset, then release it away from the rising edge.
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, back to back.
		send_word(16'h0000);          // zero right after reset is a repeat
		send_word(16'h1234);          // not an alert while idle
		send_word(16'hA10A);          // pin on generator 0, top pin
		send_word(16'h001F);
		send_word(COMMIT_WORD);
		send_word(16'hAF1B);          // full voltage on generator 1, upper byte set
		send_word(16'hFF64);
		send_word(COMMIT_WORD);
		send_word(16'hA11C);          // top frequency on generator 1
		send_word(FREQ_MAX);
		send_word(COMMIT_WORD);
		send_word(16'hA11D);          // dc shape with junk in the upper bits
		send_word(16'hFFF4);
		send_word(COMMIT_WORD);
		send_word(16'hA010);          // off command stops generator 1, then commit
		send_word(COMMIT_WORD);
		send_word(16'hA12A);          // oscilloscope id, rejected
		send_word(16'hA10E);          // unknown command nibble, rejected
		send_word(16'hA10A);          // pin one past the limit
		send_word(16'h0020);
		send_word(16'hA10C);          // frequency one below the minimum
		send_word(16'd49);
		send_word(16'hA10B);          // voltage, then a repeat of the alert
		send_word(16'hA10B);
		send_word(16'h0000);          // zero volts is legal
		send_word(16'hFFFF);          // anything but the commit word aborts
		drain();

		// Random part through the idle/stall mixes.
		run_phase(0, 0, 300, 1'b1);
		run_phase(85, 0, 270, 1'b0);
		run_phase(0, 85, 270, 1'b0);
		run_phase(13, 13, 270, 1'b1);

		// Give any stray result time to show up before judging.
		stall_pct = 0;
		repeat (8) @(posedge clk);
		if (sb.settings_due.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time,
				sb.settings_due.size());
			sb.errors++;
		end
		if (sb.errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/wgcs_pkg.sv
rtl/wgcs_core.sv
rtl/waveform_generator_command_slave.sv
verif/waveform_generator_command_slave_tb.sv
